@@ sv/longest_prefix_match_table_unit_assert.svh @@
// assertion macros for the longest prefix match table unit
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef LONGEST_PREFIX_MATCH_TABLE_UNIT_ASSERT_SVH
`define LONGEST_PREFIX_MATCH_TABLE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define LPMT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define LPMT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LPMT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define LPMT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ sv/lpmt_pkg.sv @@
// shared constants and types for the longest prefix match table unit
// no dependencies
package lpmt_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int IDX_W       = 4;
	localparam int PORT_W      = 3;

	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_LOOKUP = 1'b1;

	typedef struct packed {
		logic [31:0]       prefix;
		logic [31:0]       mask;
		logic [31:0]       gateway;
		logic [PORT_W-1:0] port;
	} route_t;

	localparam int ROUTE_W = $bits(route_t);

endpackage

@@ sv/longest_prefix_match_table_unit.sv @@
// Routing table with IPv4 longest prefix match. A write word (action = 0) loads or
// clears one slot and gives no result; a slot index at or above TABLE_DEPTH is dropped.
// A lookup word (action = 1) scans the table RAM one entry per cycle through its single
// read port and returns one result word: a lookup holds the input off through the scan,
// the RAM read and the load of the result register, so no new word is accepted until
// the lookup is through. The result register lets the next word be accepted while a
// result waits for out_ready.
// Depends on lpmt_pkg, lpmt_ram and longest_prefix_match_table_unit_assert.svh.
`include "longest_prefix_match_table_unit_assert.svh"

module longest_prefix_match_table_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       action,
	input  logic [lpmt_pkg::IDX_W-1:0] entry_index,
	input  logic                       entry_valid,
	input  logic [31:0]                entry_prefix,
	input  logic [31:0]                entry_mask,
	input  logic [31:0]                entry_gateway,
	input  logic [lpmt_pkg::PORT_W-1:0] entry_port,
	input  logic [31:0]                lookup_addr,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       hit,
	output logic [lpmt_pkg::IDX_W-1:0] match_index,
	output logic [31:0]                match_gateway,
	output logic [lpmt_pkg::PORT_W-1:0] match_port,
	output logic [31:0]                match_mask
);
	import lpmt_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]             state_q;
	logic [ADDR_W-1:0]      ctr_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [31:0]            addr_q;

	logic                   rd_s1;
	logic                   vld_s1;
	logic [ADDR_W-1:0]      idx_s1;

	logic                   found_q;
	logic [ADDR_W-1:0]      best_idx_q;
	logic [31:0]            best_mask_q;
	logic [31:0]            best_gw_q;
	logic [PORT_W-1:0]      best_port_q;

	logic                   out_valid_q;
	logic                   hit_q;
	logic [IDX_W-1:0]       match_index_q;
	logic [31:0]            match_gateway_q;
	logic [PORT_W-1:0]      match_port_q;
	logic [31:0]            match_mask_q;

	logic                   in_acc;
	logic                   wr_en;
	logic                   lookup_acc;
	logic [ADDR_W+IDX_W-1:0] idx_ext;
	logic                   in_range;
	logic [ADDR_W-1:0]      wr_addr;
	route_t                 wr_route;
	route_t                 rd_route;
	logic                   rd_en;
	logic                   cand;
	logic                   take;
	logic                   load_out;
	logic [ADDR_W+IDX_W-1:0] best_ext;

	assign in_ready   = (state_q == ST_IDLE);
	assign in_acc     = in_valid && in_ready;
	assign idx_ext    = {ADDR_W'(0), entry_index};
	assign in_range   = (idx_ext < (ADDR_W + IDX_W)'(TABLE_DEPTH));
	assign wr_addr    = idx_ext[ADDR_W-1:0];
	assign wr_en      = in_acc && (action == ACT_WRITE) && in_range;
	assign lookup_acc = in_acc && (action == ACT_LOOKUP);
	assign rd_en      = (state_q == ST_SCAN);

	assign wr_route.prefix  = entry_prefix;
	assign wr_route.mask    = entry_mask;
	assign wr_route.gateway = entry_gateway;
	assign wr_route.port    = entry_port;

	lpmt_ram #(
		.WIDTH(ROUTE_W),
		.DEPTH(TABLE_DEPTH)
	) u_route_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_route),
		.re    (rd_en),
		.raddr (ctr_q),
		.rdata (rd_route)
	);

	// compare stage on the entry read last cycle
	assign cand = rd_s1 && vld_s1 &&
		((addr_q & rd_route.mask) == (rd_route.prefix & rd_route.mask));
	assign take = cand && (!found_q || (rd_route.mask > best_mask_q));

	assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign best_ext = {IDX_W'(0), best_idx_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ctr_q   <= '0;
			valid_q <= '0;
			rd_s1   <= 1'b0;
			found_q <= 1'b0;
		end else begin
			rd_s1 <= rd_en;
			if (wr_en) begin
				valid_q[wr_addr] <= entry_valid;
			end
			if (lookup_acc) begin
				found_q <= 1'b0;
			end else if (take) begin
				found_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (lookup_acc) begin
						ctr_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (ctr_q == ADDR_W'(TABLE_DEPTH - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						ctr_q <= ctr_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// scan pipeline and running best, no reset needed
	always_ff @(posedge clk) begin
		if (lookup_acc) begin
			addr_q <= lookup_addr;
		end
		vld_s1 <= valid_q[ctr_q];
		idx_s1 <= ctr_q;
		if (take) begin
			best_idx_q  <= idx_s1;
			best_mask_q <= rd_route.mask;
			best_gw_q   <= rd_route.gateway;
			best_port_q <= rd_route.port;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// a miss returns all-zero fields
	always_ff @(posedge clk) begin
		if (load_out) begin
			hit_q           <= found_q;
			match_index_q   <= found_q ? best_ext[IDX_W-1:0] : '0;
			match_gateway_q <= found_q ? best_gw_q : '0;
			match_port_q    <= found_q ? best_port_q : '0;
			match_mask_q    <= found_q ? best_mask_q : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_q;
	assign match_index   = match_index_q;
	assign match_gateway = match_gateway_q;
	assign match_port    = match_port_q;
	assign match_mask    = match_mask_q;

	`LPMT_ASSERT_IMPL(a_rd_in_scan, clk, arst_n, rd_s1,
		(state_q == ST_SCAN) || (state_q == ST_DRAIN), "ram read data pending outside a scan")
	`LPMT_ASSERT_IMPL(a_wr_idle, clk, arst_n, wr_en,
		(state_q == ST_IDLE) && !rd_en, "table written during a scan")
	`LPMT_ASSERT_NEXT(a_scan_start, clk, arst_n, lookup_acc,
		(state_q == ST_SCAN) && (ctr_q == '0) && !found_q, "lookup did not start a clean scan")
	`LPMT_ASSERT_IMPL(a_miss_zero, clk, arst_n, out_valid && !hit,
		(match_index == '0) && (match_gateway == '0) && (match_port == '0) &&
		(match_mask == '0), "miss word carries nonzero fields")

endmodule

@@ sv/lpmt_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module lpmt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
